### sv/phs_pkg.sv
// Shared types and constants for the periodic Helmholtz stencil block.
package phs_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 32;
    localparam int SIZE_W   = 9;
    localparam int INDEX_W  = 8;
    localparam int DIFF_W   = 34;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Request codes carried in req_type.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_CENTER_COEF = 3'd0;
    localparam logic [2:0] REG_X_COEF      = 3'd1;
    localparam logic [2:0] REG_Y_COEF      = 3'd2;
    localparam logic [2:0] REG_GRID_ROWS   = 3'd3;
    localparam logic [2:0] REG_GRID_COLS   = 3'd4;

    localparam logic [COEF_W-1:0] CENTER_COEF_RESET = 32'd65536;
    localparam logic [COEF_W-1:0] X_COEF_RESET      = 32'd0;
    localparam logic [COEF_W-1:0] Y_COEF_RESET      = 32'd0;
    localparam logic [SIZE_W-1:0] GRID_ROWS_RESET   = 9'd256;
    localparam logic [SIZE_W-1:0] GRID_COLS_RESET   = 9'd256;

    typedef struct packed {
        logic                       req_type;
        logic [INDEX_W-1:0]         row;
        logic [INDEX_W-1:0]         col;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result_value;
        logic                       saturated;
    } t_out_item;

    typedef struct packed {
        logic [COEF_W-1:0] center;
        logic [COEF_W-1:0] x;
        logic [COEF_W-1:0] y;
    } t_coef;

    // Center sample and the two second differences of one query.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] u;
        logic signed [DIFF_W-1:0]   dr;
        logic signed [DIFF_W-1:0]   dc;
    } t_diff;

endpackage

### sv/phs_grid_mem.sv
// Grid sample memory: one write port and two registered read ports.
module phs_grid_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### sv/phs_arith.sv
// Weighted stencil sum: products, wide sum, rounding, saturation and output register.
module phs_arith (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  phs_pkg::t_diff     i_diff,
    input  phs_pkg::t_coef     i_coef,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output phs_pkg::t_out_item o_out_item
);

    localparam int PC_W  = 65;
    localparam int PD_W  = 67;
    localparam int SUM_W = 68;
    localparam int FRAC_DROP = 16;
    localparam int RND_W = SUM_W - FRAC_DROP;
    localparam logic signed [RND_W-1:0] RES_MAX = 52'sd2147483647;
    localparam logic signed [RND_W-1:0] RES_MIN = -52'sd2147483648;
    localparam logic signed [SUM_W-1:0] HALF    = 68'sd32768;

    logic signed [PC_W-1:0]  pc;
    logic signed [PD_W-1:0]  px;
    logic signed [PD_W-1:0]  py;
    logic signed [PC_W-1:0]  r_pc;
    logic signed [PD_W-1:0]  r_px;
    logic signed [PD_W-1:0]  r_py;
    logic                    r_prod_valid;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_sum_valid;
    logic signed [SUM_W-1:0] rnd_sum;
    logic signed [RND_W-1:0] rnd;
    logic                    out_free;
    phs_pkg::t_out_item      n_out;

    assign pc = $signed({1'b0, i_coef.center}) * i_diff.u;
    assign px = $signed({1'b0, i_coef.x}) * i_diff.dr;
    assign py = $signed({1'b0, i_coef.y}) * i_diff.dc;

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_pc <= pc;
            r_px <= px;
            r_py <= py;
        end
        if (r_prod_valid) begin
            r_sum <= SUM_W'(r_pc) - SUM_W'(r_px) - SUM_W'(r_py);
        end
    end

    // Add one half, then floor by dropping the 16 extra fraction bits.
    assign rnd_sum  = r_sum + HALF;
    assign rnd      = rnd_sum[SUM_W-1:FRAC_DROP];
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        if (rnd > RES_MAX) begin
            n_out.result_value = RES_MAX[31:0];
            n_out.saturated    = 1'b1;
        end else if (rnd < RES_MIN) begin
            n_out.result_value = RES_MIN[31:0];
            n_out.saturated    = 1'b1;
        end else begin
            n_out.result_value = rnd[31:0];
            n_out.saturated    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            r_prod_valid <= i_valid;
            if (r_prod_valid) begin
                r_sum_valid <= 1'b1;
            end else if (r_sum_valid && out_free) begin
                r_sum_valid <= 1'b0;
            end
            if (r_sum_valid && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sum_valid && out_free) begin
            o_out_item <= n_out;
        end
    end

    assign o_busy = r_prod_valid || r_sum_valid;

endmodule

### sv/periodic_helmholtz_stencil.sv
// Top level of the periodic five-point Helmholtz stencil with its register port.
//
// The input channel carries load and query transfers. A load writes one Q8.24
// sample into the grid memory at its row and column; a load outside the active
// grid is dropped. A query returns one result transfer with
// center*u - x*(uN+uS-2u) - y*(uW+uE-2u), rounded to Q8.24 and saturated.
// A query outside the active grid returns zero. Neighbors wrap at grid_rows
// and grid_cols, which are clamped to 2..MAX_ROWS and 2..MAX_COLS.
// A load is written in state S_RD0. A query holds the sequencer in states S_RD0,
// S_RD1, S_RD2 and S_DIFF while the five samples are fetched through the two
// read ports of the grid memory (reads in S_RD0, S_RD1 and S_RD2) and the
// differences are formed; the multiply, sum and output stages follow. The next
// transfer is accepted once the sequencer is idle and the differences, multiply
// and sum stages are empty. A finished result waits in the output register while
// the receiver stalls; the next item may be accepted and computed meanwhile, and
// it is held before rounding until the output register frees up.
// Reset returns the registers to their defaults and empties the pipeline; the
// grid memory is not cleared, and a cell must be loaded before it is read.
module periodic_helmholtz_stencil #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  phs_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output phs_pkg::t_out_item                  o_out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [phs_pkg::PADDR_W-1:0]         paddr,
    input  logic [phs_pkg::PDATA_W-1:0]         pwdata,
    output logic [phs_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int RSW   = $clog2(MAX_ROWS + 1);
    localparam int CSW   = $clog2(MAX_COLS + 1);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_DIFF
    } t_state;

    t_state                               r_state;
    logic [phs_pkg::COEF_W-1:0]           r_center_coef;
    logic [phs_pkg::COEF_W-1:0]           r_x_coef;
    logic [phs_pkg::COEF_W-1:0]           r_y_coef;
    logic [phs_pkg::SIZE_W-1:0]           r_grid_rows;
    logic [phs_pkg::SIZE_W-1:0]           r_grid_cols;
    phs_pkg::t_in_item                    r_item;
    logic signed [phs_pkg::SAMPLE_W-1:0]  r_u;
    logic signed [phs_pkg::SAMPLE_W-1:0]  r_un;
    logic signed [phs_pkg::SAMPLE_W-1:0]  r_us;
    logic signed [phs_pkg::SAMPLE_W-1:0]  r_uw;
    phs_pkg::t_diff                       r_diff;
    logic                                 r_diff_valid;

    logic [RSW-1:0]                       rows_c;
    logic [CSW-1:0]                       cols_c;
    logic                                 in_grid;
    logic [RIW-1:0]                       rr;
    logic [RIW-1:0]                       rp;
    logic [RIW-1:0]                       rm;
    logic [CIW-1:0]                       cc;
    logic [CIW-1:0]                       cp;
    logic [CIW-1:0]                       cm;
    logic [RSW-1:0]                       rr_next;
    logic [CSW-1:0]                       cc_next;
    logic [AW-1:0]                        raddr_a;
    logic [AW-1:0]                        raddr_b;
    logic [AW-1:0]                        addr_center;
    logic                                 mem_we;
    logic [phs_pkg::SAMPLE_W-1:0]         rdata_a;
    logic [phs_pkg::SAMPLE_W-1:0]         rdata_b;
    logic                                 cfg_write;
    logic                                 arith_busy;
    logic                                 in_accept;
    phs_pkg::t_coef                       coef;

    function automatic logic [AW-1:0] cell_addr(input logic [RIW-1:0] r,
                                                input logic [CIW-1:0] c);
        cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_coef <= phs_pkg::CENTER_COEF_RESET;
            r_x_coef      <= phs_pkg::X_COEF_RESET;
            r_y_coef      <= phs_pkg::Y_COEF_RESET;
            r_grid_rows   <= phs_pkg::GRID_ROWS_RESET;
            r_grid_cols   <= phs_pkg::GRID_COLS_RESET;
        end else if (cfg_write) begin
            case (paddr[4:2])
                phs_pkg::REG_CENTER_COEF: r_center_coef <= pwdata;
                phs_pkg::REG_X_COEF:      r_x_coef      <= pwdata;
                phs_pkg::REG_Y_COEF:      r_y_coef      <= pwdata;
                phs_pkg::REG_GRID_ROWS:   r_grid_rows   <= pwdata[phs_pkg::SIZE_W-1:0];
                phs_pkg::REG_GRID_COLS:   r_grid_cols   <= pwdata[phs_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            phs_pkg::REG_CENTER_COEF: prdata = r_center_coef;
            phs_pkg::REG_X_COEF:      prdata = r_x_coef;
            phs_pkg::REG_Y_COEF:      prdata = r_y_coef;
            phs_pkg::REG_GRID_ROWS:   prdata = phs_pkg::PDATA_W'(r_grid_rows);
            phs_pkg::REG_GRID_COLS:   prdata = phs_pkg::PDATA_W'(r_grid_cols);
            default:                  prdata = '0;
        endcase
    end

    // Active grid size, clamped to the storage.
    always_comb begin
        if (r_grid_rows < 9'd2) begin
            rows_c = RSW'(2);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows_c = RSW'(MAX_ROWS);
        end else begin
            rows_c = RSW'(r_grid_rows);
        end
        if (r_grid_cols < 9'd2) begin
            cols_c = CSW'(2);
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            cols_c = CSW'(MAX_COLS);
        end else begin
            cols_c = CSW'(r_grid_cols);
        end
    end

    // Indexes are only used when the cell lies inside the active grid.
    assign in_grid = (32'(r_item.row) < 32'(rows_c)) && (32'(r_item.col) < 32'(cols_c));
    assign rr      = RIW'(r_item.row);
    assign cc      = CIW'(r_item.col);
    assign rr_next = RSW'(rr) + RSW'(1);
    assign cc_next = CSW'(cc) + CSW'(1);
    assign rp      = (rr_next == rows_c) ? '0 : RIW'(rr_next);
    assign cp      = (cc_next == cols_c) ? '0 : CIW'(cc_next);
    assign rm      = (rr == '0) ? RIW'(rows_c - RSW'(1)) : rr - RIW'(1);
    assign cm      = (cc == '0) ? CIW'(cols_c - CSW'(1)) : cc - CIW'(1);

    assign addr_center = cell_addr(rr, cc);

    // Read schedule: center and north, then south and west, then east.
    always_comb begin
        case (r_state)
            S_RD1: begin
                raddr_a = cell_addr(rp, cc);
                raddr_b = cell_addr(rr, cm);
            end
            S_RD2: begin
                raddr_a = cell_addr(rr, cp);
                raddr_b = cell_addr(rr, cm);
            end
            default: begin
                raddr_a = addr_center;
                raddr_b = cell_addr(rm, cc);
            end
        endcase
    end

    assign mem_we = (r_state == S_RD0) && (r_item.req_type == phs_pkg::REQ_LOAD) && in_grid;

    phs_grid_mem #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (phs_pkg::SAMPLE_W)
    ) u_grid_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (addr_center),
        .i_wdata  (r_item.sample_value),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_b),
        .o_rdata_a(rdata_a),
        .o_rdata_b(rdata_b)
    );

    assign o_in_stall = (r_state != S_IDLE) || r_diff_valid || arith_busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_diff_valid <= 1'b0;
        end else begin
            r_diff_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    if (r_item.req_type == phs_pkg::REQ_LOAD) begin
                        r_state <= S_IDLE;
                    end else if (!in_grid) begin
                        // All-zero operands give a zero, unsaturated result.
                        r_diff_valid <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_RD1;
                    end
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: r_state <= S_DIFF;
                S_DIFF: begin
                    r_diff_valid <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        case (r_state)
            S_RD0: begin
                if (!in_grid) begin
                    r_diff <= '0;
                end
            end
            S_RD1: begin
                r_u  <= $signed(rdata_a);
                r_un <= $signed(rdata_b);
            end
            S_RD2: begin
                r_us <= $signed(rdata_a);
                r_uw <= $signed(rdata_b);
            end
            S_DIFF: begin
                r_diff.u  <= r_u;
                r_diff.dr <= phs_pkg::DIFF_W'(r_un) + phs_pkg::DIFF_W'(r_us)
                             - (phs_pkg::DIFF_W'(r_u) <<< 1);
                r_diff.dc <= phs_pkg::DIFF_W'($signed(rdata_a)) + phs_pkg::DIFF_W'(r_uw)
                             - (phs_pkg::DIFF_W'(r_u) <<< 1);
            end
            default: ;
        endcase
    end

    assign coef.center = r_center_coef;
    assign coef.x      = r_x_coef;
    assign coef.y      = r_y_coef;

    phs_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_diff_valid),
        .i_diff     (r_diff),
        .i_coef     (coef),
        .o_busy     (arith_busy),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule
